@@ rtl/mhcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhcc_pkg: shared types and constants for the magic hash collision check
// Item structs, the queue job, register codes and table constants.
// ----------------------------------------------------------------------------
package mhcc_pkg;

    // field widths fixed by the item format
    localparam int DATA_BITS      = 64;
    localparam int SLOT_OUT_BITS  = 12;
    localparam int SHIFT_BITS     = 6;
    localparam int CFG_IDX_BITS   = 1;

    // defaults and limits for top-level parameters
    localparam int DEF_INDEX_BITS  = 12;
    localparam int INDEX_BITS_MAX  = 14;
    localparam int DEF_QUEUE_DEPTH = 2;

    // trial tag stored with every slot word
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAGIC = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT = 1'b1;

    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 6'd52;

    // operation codes
    localparam logic OP_TEST = 1'b0;
    localparam logic OP_READ = 1'b1;

    // contents reported for an empty slot
    localparam logic [DATA_BITS-1:0] EMPTY_DATA = '1;

    typedef struct packed {
        logic                 op;
        logic                 first_of_trial;
        logic [DATA_BITS-1:0] blockers;
        logic [DATA_BITS-1:0] attack_set;
        logic [11:0]          read_slot;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_OUT_BITS-1:0] slot_index;
        logic                     collision;
        logic                     trial_failed;
        logic [DATA_BITS-1:0]     slot_data;
    } t_out_item;

    // classified item handed from front end to table engine
    typedef struct packed {
        logic                      op;
        logic                      first;
        logic [INDEX_BITS_MAX-1:0] idx;
        logic [DATA_BITS-1:0]      attack;
    } t_job;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } t_back_state;

endpackage
`default_nettype wire

@@ rtl/mhcc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhcc_front: item intake and slot hashing
// Holds the magic and shift registers, splits the 64-bit multiply into
// 32-bit partial products, then sums, shifts and emits a job per item.
// ----------------------------------------------------------------------------
module mhcc_front
    import mhcc_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [DATA_BITS-1:0]     i_cfg_data,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    input  wire                     i_hold,
    output logic                    o_job_valid,
    input  wire                     i_job_ready,
    output t_job                    o_job
);

    logic [DATA_BITS-1:0]  r_magic;
    logic [SHIFT_BITS-1:0] r_shift;

    logic                  r_s1_valid;
    logic                  r_s1_op;
    logic                  r_s1_first;
    logic [DATA_BITS-1:0]  r_s1_attack;
    logic [11:0]           r_s1_read_slot;
    logic [63:0]           r_pp_ll;
    logic [31:0]           r_pp_lh;
    logic [31:0]           r_pp_hl;

    logic                  w_accept;
    logic                  w_push;
    logic [63:0]           w_pp_ll;
    logic [31:0]           w_pp_lh;
    logic [31:0]           w_pp_hl;
    logic [DATA_BITS-1:0]  w_prod;
    logic [DATA_BITS-1:0]  w_hash;
    logic [INDEX_BITS-1:0] w_idx;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC: r_magic <= i_cfg_data;
                CFG_SHIFT: r_shift <= i_cfg_data[SHIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // handshake: stage 1 frees when its job moves into the queue
    assign w_push      = r_s1_valid && i_job_ready;
    assign o_in_ready  = !i_hold && (!r_s1_valid || i_job_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_job_valid = r_s1_valid;

    // partial products; only the low half of the cross terms survives mod 2^64
    assign w_pp_ll = i_in_data.blockers[31:0]  * r_magic[31:0];
    assign w_pp_lh = i_in_data.blockers[31:0]  * r_magic[63:32];
    assign w_pp_hl = i_in_data.blockers[63:32] * r_magic[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op        <= i_in_data.op;
            r_s1_first     <= i_in_data.first_of_trial;
            r_s1_attack    <= i_in_data.attack_set;
            r_s1_read_slot <= i_in_data.read_slot;
            r_pp_ll        <= w_pp_ll;
            r_pp_lh        <= w_pp_lh;
            r_pp_hl        <= w_pp_hl;
        end
    end

    // product sum, shift and slot selection
    assign w_prod = r_pp_ll + {r_pp_lh + r_pp_hl, 32'd0};
    assign w_hash = w_prod >> r_shift;
    assign w_idx  = (r_s1_op == OP_TEST) ? w_hash[INDEX_BITS-1:0]
                                         : INDEX_BITS'(r_s1_read_slot);

    always_comb begin
        o_job.op     = r_s1_op;
        o_job.first  = r_s1_first;
        o_job.idx    = INDEX_BITS_MAX'(w_idx);
        o_job.attack = r_s1_attack;
    end

endmodule
`default_nettype wire

@@ rtl/mhcc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhcc_queue: job queue between front end and table engine
// Small register FIFO so hashing and table work stall independently.
// ----------------------------------------------------------------------------
module mhcc_queue
    import mhcc_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  wire  i_pop_ready,
    output t_job o_pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    t_job                r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/mhcc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhcc_back: slot table engine
// Slot read per job, write only for a clean test. Each word carries a trial
// tag; a slot is live when its tag matches the current trial, so a new
// trial empties the table by bumping the tag. A sweep rewrites all tags
// after reset and whenever the tag counter wraps.
// ----------------------------------------------------------------------------
module mhcc_back
    import mhcc_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_data
);

    localparam int SLOTS     = 1 << INDEX_BITS;
    localparam int WORD_BITS = EPOCH_BITS + DATA_BITS;

    logic [WORD_BITS-1:0]  mem [SLOTS];

    t_back_state           r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_cnt, n_clr_cnt;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic                  r_failed, n_failed;
    logic                  r_pending, n_pending;
    logic                  r_out_valid, n_out_valid;
    t_job                  r_cur, n_cur;
    t_out_item             r_out, n_out;
    logic [WORD_BITS-1:0]  r_rd;

    logic                  w_we;
    logic                  w_re;
    logic [INDEX_BITS-1:0] w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [INDEX_BITS-1:0] w_cur_idx;
    logic [EPOCH_BITS-1:0] w_tag;
    logic [DATA_BITS-1:0]  w_data;
    logic                  w_live;
    logic                  w_collision;
    logic                  w_store;
    logic                  w_out_free;

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // slot lookup against the registered read word
    assign w_cur_idx   = r_cur.idx[INDEX_BITS-1:0];
    assign w_tag       = r_rd[WORD_BITS-1 -: EPOCH_BITS];
    assign w_data      = r_rd[DATA_BITS-1:0];
    assign w_live      = (w_tag == r_epoch);
    assign w_collision = (r_cur.op == OP_TEST) && w_live && (w_data != r_cur.attack);
    assign w_store     = (r_cur.op == OP_TEST) && !w_collision && !r_failed;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_epoch     <= EPOCH_ONE;
            r_failed    <= 1'b0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_epoch     <= n_epoch;
            r_failed    <= n_failed;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    // next state and table control
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_epoch     = r_epoch;
        n_failed    = r_failed;
        n_pending   = r_pending;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_clr_cnt;
        w_wdata     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // tag zero never matches a live trial
                w_we    = 1'b1;
                w_waddr = r_clr_cnt;
                w_wdata = '0;
                if (&r_clr_cnt) begin
                    n_clr_cnt = '0;
                    n_pending = 1'b0;
                    n_state   = r_pending ? ST_READ : ST_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_cur   = i_job;
                    n_state = ST_READ;
                    if (i_job.first) begin
                        n_failed = 1'b0;
                        if (r_epoch == '1) begin
                            // tag wrap: sweep before this item runs
                            n_epoch   = EPOCH_ONE;
                            n_pending = 1'b1;
                            n_state   = ST_CLEAR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                w_re    = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.slot_index   = SLOT_OUT_BITS'(w_cur_idx);
                    n_out.collision    = w_collision;
                    n_out.trial_failed = r_failed || w_collision;
                    n_failed           = r_failed || w_collision;
                    if (w_store) begin
                        n_out.slot_data = r_cur.attack;
                    end else if (w_live) begin
                        n_out.slot_data = w_data;
                    end else begin
                        n_out.slot_data = EMPTY_DATA;
                    end
                    if (w_store) begin
                        w_we    = 1'b1;
                        w_waddr = w_cur_idx;
                        w_wdata = {r_epoch, r_cur.attack};
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_cur_idx];
        end
    end

    // a collision always leaves the trial marked as failed
    a_collision_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.collision) |-> r_out.trial_failed)
        else $error("collision reported without trial failure");

    // table writes from a lookup only for a clean test in a live trial
    a_store_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && w_we) |-> (!r_failed && r_cur.op == OP_TEST))
        else $error("slot written after failure or by a read");

    // a result only appears from the check step
    a_out_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_CHECK))
        else $error("result raised outside check step");

    // the swept tag value is never a live trial
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("trial tag collides with cleared tag");

endmodule
`default_nettype wire

@@ rtl/magic_hash_collision_check_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: the table engine runs the accept, slot read and check steps for
//   one item before it takes the next; the check step waits for the output.
// Reset: synchronous, active low; then a sweep of all 2^INDEX_BITS slots
//   rewrites the slot tags, during which no item is accepted. The same sweep
//   runs on every 255th first-of-trial item, when the trial tag wraps.
// ----------------------------------------------------------------------------
// magic_hash_collision_check_core: multiply-shift magic verification
// Front end hashes boards into slots, a short queue decouples it from the
// table engine that detects collisions and serves slot reads.
// ----------------------------------------------------------------------------
module magic_hash_collision_check_core
    import mhcc_pkg::*;
#(
    parameter int INDEX_BITS  = DEF_INDEX_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire [DATA_BITS-1:0]    i_cfg_data,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output t_out_item              o_out_data
);

    logic w_fe_valid;
    logic w_fe_ready;
    t_job w_fe_job;
    logic w_be_valid;
    logic w_be_ready;
    t_job w_be_job;
    logic w_clearing;

    // hashing front end
    mhcc_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_hold      (w_clearing),
        .o_job_valid (w_fe_valid),
        .i_job_ready (w_fe_ready),
        .o_job       (w_fe_job)
    );

    // job queue
    mhcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fe_valid),
        .o_push_ready (w_fe_ready),
        .i_push_data  (w_fe_job),
        .o_pop_valid  (w_be_valid),
        .i_pop_ready  (w_be_ready),
        .o_pop_data   (w_be_job)
    );

    // slot table engine
    mhcc_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_be_valid),
        .o_job_ready (w_be_ready),
        .i_job       (w_be_job),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
